### src/lcp_array_from_suffix_array_assert.svh
// Assertion macros for the LCP engine checkers.
// Each expects clk and rst_n in the scope where it is used.
`ifndef LCP_ARRAY_FROM_SUFFIX_ARRAY_ASSERT_SVH
`define LCP_ARRAY_FROM_SUFFIX_ARRAY_ASSERT_SVH

// Same-cycle implication.
`define LCP_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LCP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/lcp_pkg.sv
package lcp_pkg;

    localparam int MAX_TEXT = 4096;
    localparam int ADDR_W   = $clog2(MAX_TEXT);
    localparam int LEN_W    = ADDR_W + 1;
    localparam int BYTE_W   = 8;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [LEN_W-1:0]  len_t;

    typedef struct packed {
        logic              kind;
        addr_t             position;
        logic [BYTE_W-1:0] text_byte;
        addr_t             sa_entry;
        logic              last;
    } item_t;

    typedef struct packed {
        logic  valid;
        addr_t lcp_value;
        logic  out_of_range;
    } rsp_t;

endpackage

### src/lcp_item_if.sv
interface lcp_item_if;
    import lcp_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    addr_t             position;
    logic [BYTE_W-1:0] text_byte;
    addr_t             sa_entry;
    logic              last;

    modport source (
        output valid, kind, position, text_byte, sa_entry, last,
        input  ready
    );

    modport sink (
        input  valid, kind, position, text_byte, sa_entry, last,
        output ready
    );
endinterface

### src/lcp_result_if.sv
interface lcp_result_if;
    import lcp_pkg::*;

    logic  valid;
    logic  ready;
    addr_t lcp_value;
    logic  out_of_range;

    modport source (
        output valid, lcp_value, out_of_range,
        input  ready
    );

    modport sink (
        input  valid, lcp_value, out_of_range,
        output ready
    );
endinterface

### src/lcp_core.sv
module lcp_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  lcp_pkg::item_t cmd,
    output logic           busy,
    output lcp_pkg::rsp_t  rsp
);
    import lcp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_RANK_RD,
        S_RANK_WR,
        S_SCAN_RD,
        S_SCAN_RANK,
        S_SCAN_SUF,
        S_CMP_RD,
        S_CMP_CHK,
        S_READ
    } state_t;

    state_t state_reg, state_next;
    len_t   len_reg, len_next;
    len_t   cnt_reg, cnt_next;
    len_t   m_reg, m_next;
    addr_t  rk_reg, rk_next;
    addr_t  j_reg, j_next;

    logic [BYTE_W-1:0] text_mem [MAX_TEXT];
    addr_t             sfx_mem  [MAX_TEXT];
    addr_t             rank_mem [MAX_TEXT];
    addr_t             lcp_mem  [MAX_TEXT];

    logic [BYTE_W-1:0] text_a_reg, text_b_reg;
    addr_t             sfx_rd_reg, rank_rd_reg, lcp_rd_reg;

    logic  load_we;
    addr_t text_ra, text_rb, sfx_ra, rank_ra, lcp_ra;
    logic  rank_we, lcp_we;
    addr_t rank_wa, rank_wd, lcp_wa, lcp_wd;

    len_t  i_sum, j_ext, j_sum, rk_ext, s_ext, pos_ext;
    logic  cnt_last, match_ok;

    assign i_sum    = cnt_reg + m_reg;
    assign j_ext    = {1'b0, j_reg};
    assign j_sum    = j_ext + m_reg;
    assign rk_ext   = {1'b0, rank_rd_reg};
    assign s_ext    = {1'b0, sfx_rd_reg};
    assign pos_ext  = {1'b0, cmd.position};
    assign cnt_last = (cnt_reg + LEN_W'(1)) == len_reg;
    assign match_ok = (i_sum < len_reg) && (j_ext < len_reg) && (j_sum < len_reg)
                      && (text_a_reg == text_b_reg);

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        m_next     = m_reg;
        rk_next    = rk_reg;
        j_next     = j_reg;
        load_we    = 1'b0;
        text_ra    = i_sum[ADDR_W-1:0];
        text_rb    = j_sum[ADDR_W-1:0];
        sfx_ra     = cnt_reg[ADDR_W-1:0];
        rank_ra    = cnt_reg[ADDR_W-1:0];
        lcp_ra     = cmd.position;
        rank_we    = 1'b0;
        rank_wa    = cnt_reg[ADDR_W-1:0];
        rank_wd    = '0;
        lcp_we     = 1'b0;
        lcp_wa     = cnt_reg[ADDR_W-1:0];
        lcp_wd     = '0;
        rsp        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.kind == KIND_LOAD)
                    begin
                        load_we = 1'b1;
                        if (cmd.last)
                        begin
                            len_next   = pos_ext + LEN_W'(1);
                            cnt_next   = '0;
                            state_next = S_CLEAR;
                        end
                    end
                    else if (pos_ext < len_reg)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        rsp.valid        = 1'b1;
                        rsp.out_of_range = 1'b1;
                    end
                end
            end
            S_CLEAR:
            begin
                rank_we = 1'b1;
                lcp_we  = 1'b1;
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = S_RANK_RD;
                end
                else
                begin
                    cnt_next = cnt_reg + LEN_W'(1);
                end
            end
            S_RANK_RD:
            begin
                state_next = S_RANK_WR;
            end
            S_RANK_WR:
            begin
                if (s_ext < len_reg)
                begin
                    rank_we = 1'b1;
                    rank_wa = sfx_rd_reg;
                    rank_wd = cnt_reg[ADDR_W-1:0];
                end
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    m_next     = '0;
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    cnt_next   = cnt_reg + LEN_W'(1);
                    state_next = S_RANK_RD;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_RANK;
            end
            S_SCAN_RANK:
            begin
                if (rank_rd_reg == '0 || rk_ext >= len_reg)
                begin
                    // rank zero has no predecessor
                    if (rank_rd_reg == '0)
                    begin
                        lcp_we = 1'b1;
                        lcp_wa = '0;
                    end
                    m_next = '0;
                    if (cnt_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + LEN_W'(1);
                        state_next = S_SCAN_RD;
                    end
                end
                else
                begin
                    rk_next    = rank_rd_reg;
                    sfx_ra     = rank_rd_reg - ADDR_W'(1);
                    state_next = S_SCAN_SUF;
                end
            end
            S_SCAN_SUF:
            begin
                j_next     = sfx_rd_reg;
                state_next = S_CMP_RD;
            end
            S_CMP_RD:
            begin
                state_next = S_CMP_CHK;
            end
            S_CMP_CHK:
            begin
                if (match_ok)
                begin
                    m_next     = m_reg + LEN_W'(1);
                    state_next = S_CMP_RD;
                end
                else
                begin
                    lcp_we = 1'b1;
                    lcp_wa = rk_reg;
                    lcp_wd = m_reg[ADDR_W-1:0];
                    if (m_reg != '0)
                    begin
                        m_next = m_reg - LEN_W'(1);
                    end
                    if (cnt_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + LEN_W'(1);
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_READ:
            begin
                rsp.valid     = 1'b1;
                rsp.lcp_value = lcp_rd_reg;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
            cnt_reg   <= '0;
            m_reg     <= '0;
            rk_reg    <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            m_reg     <= m_next;
            rk_reg    <= rk_next;
            j_reg     <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            text_mem[cmd.position] <= cmd.text_byte;
        end
        text_a_reg <= text_mem[text_ra];
        text_b_reg <= text_mem[text_rb];
    end

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            sfx_mem[cmd.position] <= cmd.sa_entry;
        end
        sfx_rd_reg <= sfx_mem[sfx_ra];
    end

    always_ff @(posedge clk)
    begin
        if (rank_we)
        begin
            rank_mem[rank_wa] <= rank_wd;
        end
        rank_rd_reg <= rank_mem[rank_ra];
    end

    always_ff @(posedge clk)
    begin
        if (lcp_we)
        begin
            lcp_mem[lcp_wa] <= lcp_wd;
        end
        lcp_rd_reg <= lcp_mem[lcp_ra];
    end

endmodule

### src/lcp_array_from_suffix_array.sv
// A load beat writes the text and suffix stores as it is taken. An in-range read goes through
// the registered LCP store read and the read state to the output register; an out-of-range
// read goes straight to it. The last load starts the pass: clear the rank and LCP stores,
// rank each suffix entry, then scan with at most 3n compares on the single text compare unit.
// Throughput: one beat at a time; input ready drops while a pass or read runs or a result waits.
// Reset: asynchronous, active low; clears the sequencer, text length and output valid.
module lcp_array_from_suffix_array (
    input  logic        clk,
    input  logic        rst_n,
    lcp_item_if.sink    item,
    lcp_result_if.source result
);
    import lcp_pkg::*;

    item_t cmd;
    rsp_t  rsp;
    logic  busy;
    logic  cmd_valid;

    logic  out_valid_reg, out_valid_next;
    addr_t out_lcp_reg;
    logic  out_oor_reg;

    // Take a beat only when the engine is idle and the result slot is empty;
    // this keeps loads from racing a pending read.
    assign item.ready = !busy && !out_valid_reg;
    assign cmd_valid  = item.valid && item.ready;

    assign cmd.kind      = item.kind;
    assign cmd.position  = item.position;
    assign cmd.text_byte = item.text_byte;
    assign cmd.sa_entry  = item.sa_entry;
    assign cmd.last      = item.last;

    // Sequencer, the four stores and the shared compare unit.
    lcp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .busy      (busy),
        .rsp       (rsp)
    );

    // Output register: hold the result until the sink takes the beat.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (rsp.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp.valid)
        begin
            out_lcp_reg <= rsp.lcp_value;
            out_oor_reg <= rsp.out_of_range;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.lcp_value    = out_lcp_reg;
    assign result.out_of_range = out_oor_reg;

endmodule

### src/lcp_chk.sv
`include "lcp_array_from_suffix_array_assert.svh"

module lcp_chk (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  item_valid,
    input logic                  item_ready,
    input logic                  item_kind,
    input logic                  item_last,
    input logic                  result_valid,
    input logic                  result_ready,
    input logic [lcp_pkg::ADDR_W-1:0] result_lcp_value,
    input logic                  result_out_of_range
);
    import lcp_pkg::*;

    logic take_load_last;
    logic take_read;

    assign take_load_last = item_valid && item_ready && (item_kind == KIND_LOAD) && item_last;
    assign take_read      = item_valid && item_ready && (item_kind == KIND_READ);

    `LCP_ASSERT_NOW(a_oor_zero, result_valid && result_out_of_range,
        result_lcp_value == '0, "out-of-range result carries nonzero lcp")
    `LCP_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
        result_valid && $stable(result_lcp_value) && $stable(result_out_of_range),
        "stalled result changed")
    `LCP_ASSERT_NOW(a_no_take_pending, result_valid, !item_ready,
        "input ready while a result waits")
    `LCP_ASSERT_NEXT(a_pass_busy, take_load_last, !item_ready,
        "input ready right after the last load")
    `LCP_ASSERT_NEXT(a_read_busy, take_read, !item_ready,
        "input ready right after a read")

endmodule

bind lcp_array_from_suffix_array lcp_chk u_lcp_chk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .item_valid          (item.valid),
    .item_ready          (item.ready),
    .item_kind           (item.kind),
    .item_last           (item.last),
    .result_valid        (result.valid),
    .result_ready        (result.ready),
    .result_lcp_value    (result.lcp_value),
    .result_out_of_range (result.out_of_range)
);

### tb/lcp_array_from_suffix_array_tb.sv
module lcp_array_from_suffix_array_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lcp_pkg::*;

    // Run guard: far above the slowest legal run (every read stalled by the
    // receiver, every beat delayed by the sender, every pass at its worst
    // case).
    localparam int CYCLE_LIMIT = 500_000;
    // Settle time after the last result: covers an in-range read plus margin.
    localparam int TAIL_CYCLES = 100;
    // Length of the receiver hold-off in the back-pressure test.
    localparam int HOLD_OFF_CYCLES = 300;

    // How a test builds the suffix entries for a text it loads.
    typedef enum int {
        SA_SORTED,      // true suffix array of the text
        SA_PERMUTED,    // random permutation of 0..n-1
        SA_ARBITRARY,   // duplicates and entries at or beyond the length
        SA_GIVEN        // left as the caller wrote it
    } sa_shape_t;

    // One read result as the block should return it.
    typedef struct {
        addr_t lcp_value;
        logic  out_of_range;
    } lcp_read_t;

    logic clk = 1'b0;
    logic rst_n;

    lcp_item_if   item_ch ();
    lcp_result_if result_ch ();

    lcp_array_from_suffix_array dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    always
    begin
        #5ns clk = 1'b1;
        #5ns clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the engine: stores, length and running match length.
    // ------------------------------------------------------------------
    logic [7:0] text_mem [MAX_TEXT];
    int         sa_mem   [MAX_TEXT];
    int         rank_mem [MAX_TEXT];
    addr_t      lcp_mem  [MAX_TEXT];
    int         text_len;
    int         run_match;

    // Track which positions were ever loaded. A last load at p is only legal
    // when every position below p has been written, otherwise the pass reads
    // stores that hold nothing defined.
    bit loaded [MAX_TEXT];
    int loaded_prefix;

    // Read results still owed by the block, oldest first.
    lcp_read_t pending_lcp_reads [$];

    // Text and suffix entries of the set a test is about to load.
    logic [7:0] set_text [MAX_TEXT];
    int         set_sa   [MAX_TEXT];
    int         load_order [MAX_TEXT];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    int beats_sent;
    int mismatches;
    int cycles_run;

    // Linear LCP pass over the loaded text, run when the last load lands.
    function automatic void run_lcp_pass();
        int n, rk, j;
        n = text_len;
        // Clear ranks and LCP entries first so a suffix array that is not a
        // permutation still leaves defined values behind.
        for (int r = 0; r < n; r++)
        begin
            rank_mem[r] = 0;
            lcp_mem[r]  = '0;
        end
        // Entries at or beyond the length write no rank.
        for (int r = 0; r < n; r++)
        begin
            if (sa_mem[r] < n)
                rank_mem[sa_mem[r]] = r;
        end
        run_match = 0;
        for (int i = 0; i < n; i++)
        begin
            rk = rank_mem[i];
            if (rk == 0)
            begin
                // Rank zero has no predecessor: LCP 0, restart the match.
                lcp_mem[0] = '0;
                run_match  = 0;
                continue;
            end
            j = sa_mem[rk - 1];
            // An out-of-range partner matches nothing; the carried length
            // is stored as it stands.
            while (i + run_match < n && j < n && j + run_match < n &&
                   text_mem[i + run_match] == text_mem[j + run_match])
                run_match++;
            lcp_mem[rk] = addr_t'(run_match);
            if (run_match > 0)
                run_match--;
        end
    endfunction

    // Apply one accepted beat to the shadow and queue its result, if any.
    function automatic void predict_beat(input item_t beat);
        lcp_read_t want;
        int pos;
        pos = int'(beat.position);
        if (beat.kind == KIND_LOAD)
        begin
            text_mem[pos] = beat.text_byte;
            sa_mem[pos]   = int'(beat.sa_entry);
            loaded[pos]   = 1'b1;
            while (loaded_prefix < MAX_TEXT && loaded[loaded_prefix])
                loaded_prefix++;
            if (beat.last)
            begin
                text_len = pos + 1;
                run_lcp_pass();
            end
        end
        else
        begin
            if (pos < text_len)
            begin
                want.lcp_value    = lcp_mem[pos];
                want.out_of_range = 1'b0;
            end
            else
            begin
                want.lcp_value    = '0;
                want.out_of_range = 1'b1;
            end
            pending_lcp_reads = {pending_lcp_reads, want};
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side. Drive at the falling edge, sample ready at the rising
    // edge, predict once the beat is taken.
    // ------------------------------------------------------------------
    task automatic send_beat(input item_t beat);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid = 1'b0;
            @(negedge clk);
        end
        item_ch.valid     = 1'b1;
        item_ch.kind      = beat.kind;
        item_ch.position  = beat.position;
        item_ch.text_byte = beat.text_byte;
        item_ch.sa_entry  = beat.sa_entry;
        item_ch.last      = beat.last;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        predict_beat(beat);
        beats_sent++;
        @(negedge clk);
        // Drop valid; a following beat raises it again in this same step
        // with a blocking write, which the block never samples.
        item_ch.valid = 1'b0;
    endtask

    task automatic send_load(input int pos, input int text_byte, input int sa_entry,
                             input bit is_last);
        item_t beat;
        beat.kind      = KIND_LOAD;
        beat.position  = addr_t'(pos);
        beat.text_byte = 8'(text_byte);
        beat.sa_entry  = addr_t'(sa_entry);
        beat.last      = is_last;
        send_beat(beat);
    endtask

    // Fields other than the index are don't-care on a read: randomize them.
    task automatic read_lcp(input int idx);
        item_t beat;
        beat.kind      = KIND_READ;
        beat.position  = addr_t'(idx);
        beat.text_byte = 8'($urandom_range(255));
        beat.sa_entry  = addr_t'($urandom_range(MAX_TEXT - 1));
        beat.last      = 1'($urandom_range(1));
        send_beat(beat);
    endtask

    // Hold until every owed result has come back.
    task automatic wait_for_results();
        while (pending_lcp_reads.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Set construction.
    // ------------------------------------------------------------------
    function automatic bit suffix_precedes(input int a, input int b, input int n);
        int k;
        k = 0;
        while (a + k < n && b + k < n)
        begin
            if (set_text[a + k] != set_text[b + k])
                return set_text[a + k] < set_text[b + k];
            k++;
        end
        // The suffix that runs out first is the smaller one.
        return a + k == n;
    endfunction

    function automatic void sort_suffixes(input int n);
        int key, j;
        for (int p = 0; p < n; p++)
            set_sa[p] = p;
        for (int p = 1; p < n; p++)
        begin
            key = set_sa[p];
            j   = p - 1;
            while (j >= 0 && suffix_precedes(key, set_sa[j], n))
            begin
                set_sa[j + 1] = set_sa[j];
                j--;
            end
            set_sa[j + 1] = key;
        end
    endfunction

    // Fill load_order with 0..n-1, shuffled when asked.
    function automatic void scramble_order(input int n, input bit mix);
        int j, t;
        for (int p = 0; p < n; p++)
            load_order[p] = p;
        if (mix)
        begin
            for (int p = n - 1; p > 0; p--)
            begin
                j = $urandom_range(p, 0);
                t = load_order[p];
                load_order[p] = load_order[j];
                load_order[j] = t;
            end
        end
    endfunction

    // Draw a text over a few symbols, so suffixes repeat and matches run long.
    function automatic void fill_text(input int n, input int symbols);
        int base;
        base = $urandom_range(255);
        for (int p = 0; p < n; p++)
        begin
            if (symbols >= 256)
                set_text[p] = 8'($urandom_range(255));
            else
                set_text[p] = 8'(base + $urandom_range(symbols - 1));
        end
    endfunction

    // Load set_text[0..n-1]: all positions but the last in any order, then
    // the last position with last set, which starts the pass.
    task automatic load_set(input int n, input sa_shape_t shape, input bit shuffled);
        case (shape)
            SA_SORTED:
                sort_suffixes(n);
            SA_PERMUTED:
            begin
                scramble_order(n, 1'b1);
                for (int p = 0; p < n; p++)
                    set_sa[p] = load_order[p];
            end
            SA_ARBITRARY:
            begin
                for (int p = 0; p < n; p++)
                    set_sa[p] = ($urandom_range(7) == 0) ? $urandom_range(MAX_TEXT - 1)
                                                         : $urandom_range(n + 2);
            end
            default:
                ;
        endcase
        scramble_order(n - 1, shuffled);
        for (int k = 0; k < n - 1; k++)
            send_load(load_order[k], set_text[load_order[k]], set_sa[load_order[k]], 1'b0);
        send_load(n - 1, set_text[n - 1], set_sa[n - 1], 1'b1);
    endtask

    // Mostly indexes up to and including the length; now and then anywhere.
    function automatic int pick_read_index(input int n);
        if ($urandom_range(9) == 0)
            return $urandom_range(MAX_TEXT - 1);
        return $urandom_range(n, 0);
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Nothing computed yet: length is zero, every read is out of range.
    task automatic test_reads_before_compute();
        read_lcp(0);
        read_lcp(MAX_TEXT - 1);
    endtask

    // Classic six-symbol text with a true suffix array, extreme byte values.
    task automatic test_banana_text();
        set_text[0] = 8'hFF;
        set_text[1] = 8'h00;
        set_text[2] = 8'h7F;
        set_text[3] = 8'h00;
        set_text[4] = 8'h7F;
        set_text[5] = 8'h00;
        load_set(6, SA_SORTED, 1'b0);
        for (int idx = 0; idx <= 6; idx++)
            read_lcp(idx);
    endtask

    // Non-permutation suffix entries: one at the top of the range, one
    // position left without a rank, and an out-of-range partner right after
    // a match so the carried length is stored unchanged.
    task automatic test_degenerate_suffix_entries();
        for (int p = 0; p < 4; p++)
            set_text[p] = 8'h00;
        set_sa[0] = 2;
        set_sa[1] = 0;
        set_sa[2] = MAX_TEXT - 1;
        set_sa[3] = 1;
        load_set(4, SA_GIVEN, 1'b0);
        for (int idx = 0; idx < 4; idx++)
            read_lcp(idx);
    endtask

    // Shortest text: one position, rank zero only.
    task automatic test_single_symbol_text();
        set_text[0] = 8'hFF;
        set_sa[0]   = 0;
        load_set(1, SA_GIVEN, 1'b0);
        read_lcp(0);
        read_lcp(1);
    endtask

    // Longer periodic text with one break: long carried matches through
    // the whole pass.
    task automatic test_long_periodic_text();
        logic [7:0] motif [5];
        int n;
        n = 160;
        for (int k = 0; k < 5; k++)
            motif[k] = 8'($urandom_range(255));
        for (int p = 0; p < n; p++)
            set_text[p] = motif[p % 5];
        set_text[$urandom_range(n - 1)] = 8'($urandom_range(255));
        load_set(n, SA_SORTED, 1'b1);
        read_lcp(n - 1);
        read_lcp(n);
        repeat (18)
            read_lcp(pick_read_index(n));
    endtask

    // Hold the receiver off for a long stretch while reads keep coming:
    // one result parks in the block and the input stalls behind it.
    task automatic test_result_backpressure();
        fill_text(8, 2);
        load_set(8, SA_SORTED, 1'b1);
        wait_for_results();
        hold_cycles = HOLD_OFF_CYCLES;
        for (int idx = 0; idx < 10; idx++)
            read_lcp(idx);
    endtask

    // Mostly well-formed sets with random content, plus stray loads, stray
    // reads and early last loads that recompute over stale stores.
    task automatic test_random_mix(input int budget);
        int stop_at, pick, roll, n, symbols, top;
        sa_shape_t shape;
        stop_at = beats_sent + budget;
        while (beats_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 78)
            begin
                roll = $urandom_range(99);
                if (roll < 70)
                    n = $urandom_range(12, 1);
                else if (roll < 95)
                    n = $urandom_range(40, 13);
                else
                    n = $urandom_range(120, 41);
                case ($urandom_range(4))
                    0:       symbols = 1;
                    1:       symbols = 2;
                    2:       symbols = 3;
                    3:       symbols = 4;
                    default: symbols = 256;
                endcase
                fill_text(n, symbols);
                roll = $urandom_range(99);
                if (roll < 80)
                    shape = SA_SORTED;
                else if (roll < 92)
                    shape = SA_PERMUTED;
                else
                    shape = SA_ARBITRARY;
                load_set(n, shape, 1'b1);
                repeat ($urandom_range(n + 2, 1))
                    read_lcp(pick_read_index(n));
            end
            else if (pick < 88)
            begin
                // Stray load anywhere; it lands in the stores but starts nothing.
                send_load($urandom_range(MAX_TEXT - 1), $urandom_range(255),
                          $urandom_range(MAX_TEXT - 1), 1'b0);
            end
            else if (pick < 96)
            begin
                read_lcp($urandom_range(MAX_TEXT - 1));
            end
            else
            begin
                // Early last: only where everything below is already loaded.
                top = (loaded_prefix < MAX_TEXT) ? loaded_prefix : MAX_TEXT - 1;
                send_load($urandom_range(top, 0), $urandom_range(255),
                          $urandom_range(MAX_TEXT - 1), 1'b1);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Output side.
    // ------------------------------------------------------------------

    // Drive ready at the falling edge; a pending hold-off wins over the
    // random idling and is counted down here.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            result_ch.ready = 1'b0;
            hold_cycles--;
        end
        else
            result_ch.ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare every result beat against the oldest owed read.
    always @(posedge clk)
    begin
        lcp_read_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_lcp_reads.size() == 0)
            begin
                $error("result beat with no read owed: lcp_value=%0d out_of_range=%0b",
                       result_ch.lcp_value, result_ch.out_of_range);
                mismatches++;
            end
            else
            begin
                want = pending_lcp_reads.pop_front();
                if (result_ch.lcp_value !== want.lcp_value)
                begin
                    $error("lcp_value: expected %0d, actual %0d",
                           want.lcp_value, result_ch.lcp_value);
                    mismatches++;
                end
                if (result_ch.out_of_range !== want.out_of_range)
                begin
                    $error("out_of_range: expected %0b, actual %0b",
                           want.out_of_range, result_ch.out_of_range);
                    mismatches++;
                end
            end
        end
    end

    // Run guard.
    always @(posedge clk)
    begin
        cycles_run++;
        if (cycles_run >= CYCLE_LIMIT)
        begin
            $display("lcp_array_from_suffix_array verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n              = 1'b0;
        item_ch.valid      = 1'b0;
        item_ch.kind       = KIND_LOAD;
        item_ch.position   = '0;
        item_ch.text_byte  = '0;
        item_ch.sa_entry   = '0;
        item_ch.last       = 1'b0;
        result_ch.ready    = 1'b0;
        text_len           = 0;
        run_match          = 0;
        loaded_prefix      = 0;
        hold_cycles        = 0;
        beats_sent         = 0;
        mismatches         = 0;
        cycles_run         = 0;
        for (int p = 0; p < MAX_TEXT; p++)
            loaded[p] = 1'b0;

        // Phase one: sender idles now and then, receiver most of the time.
        send_idle_pct = 18;
        recv_idle_pct = 68;

        repeat (10)
            @(negedge clk);
        rst_n = 1'b1;

        test_reads_before_compute();
        test_banana_text();
        test_degenerate_suffix_entries();
        test_single_symbol_text();
        test_random_mix(370);
        wait_for_results();

        // Phase two: swap the idling.
        send_idle_pct = 68;
        recv_idle_pct = 18;
        test_long_periodic_text();
        test_random_mix(370);
        wait_for_results();

        // Phase three: no idling, plus the long receiver hold-off.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_result_backpressure();
        test_random_mix(370);
        wait_for_results();

        repeat (TAIL_CYCLES)
            @(negedge clk);

        if (mismatches == 0 && pending_lcp_reads.size() == 0)
            $display("lcp_array_from_suffix_array verification clean");
        else
            $display("lcp_array_from_suffix_array verification failed");
        $finish;
    end

endmodule
